[sv/kcl_pkg.sv]
package kcl_pkg;

  localparam int unsigned ScanW   = 8;
  localparam int unsigned SymW    = 4;
  localparam int unsigned CodeW   = 24;
  localparam int unsigned AdcBits = 10;
  localparam int unsigned DigW    = 4;
  localparam int unsigned NumKeys = 16;
  localparam int unsigned NumTrip = 6;
  localparam int unsigned CfgW    = 3;
  localparam int unsigned CfgDataW = 24;

  // equals and clear never take part in a code match
  localparam logic [SymW-1:0] SymEquals = 4'd14;

  // scan code for each symbol: digits 0-9, + - * /, equals, clear
  localparam logic [ScanW-1:0] ScanTable [NumKeys] = '{
    8'd215, 8'd235, 8'd219, 8'd187, 8'd237, 8'd221, 8'd189, 8'd238,
    8'd222, 8'd190, 8'd119, 8'd123, 8'd125, 8'd126, 8'd183, 8'd231
  };

  localparam logic [CodeW-1:0]   ArmCodeRst    = 24'hC5202C;
  localparam logic [CodeW-1:0]   DisarmCodeRst = 24'hA0381A;
  localparam logic [AdcBits-1:0] TripOneRst    = 10'd819;
  localparam logic [AdcBits-1:0] TripTwoRst    = 10'd614;
  localparam logic [AdcBits-1:0] LowClipRst    = 10'd205;

  typedef enum logic [CfgW-1:0] {
    RegArmCode    = 3'd0,
    RegDisarmCode = 3'd1,
    RegTripOne    = 3'd2,
    RegTripTwo    = 3'd3,
    RegLowClip    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    KindKey  = 1'b0,
    KindTick = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StatusReadout   = 2'd0,
    StatusAllClear  = 2'd1,
    StatusOneTrip   = 2'd2,
    StatusIntrusion = 2'd3
  } status_e;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            recognized;
  } key_res_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] count;
    logic [2:0] index;
  } sense_res_t;

endpackage

[sv/keypad_code_lock_alarm.sv]
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   kind, scan_code, digital_sensors, analog_one/two
// out      output     out_valid_o / out_ready_i armed .. shown_two, one word per input word
// cfg      input      cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// one word per cycle sustained while the output is not stalled; an accepted word
// passes the input register, then key/sensor logic into the output register.
// the input register takes a word when empty or when the output register is free
// or being drained, so a stalled output backs up one word in each register.
// reset clears the lock state, leds and the handshake flags; config registers
// return to their default codes and thresholds.
module keypad_code_lock_alarm #(
  parameter int unsigned CodeLength = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kcl_pkg::CfgW-1:0]          cfg_addr_i,
  input  logic [kcl_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic [kcl_pkg::ScanW-1:0]         scan_code_i,
  input  logic [kcl_pkg::DigW-1:0]          digital_sensors_i,
  input  logic [kcl_pkg::AdcBits-1:0]       analog_one_i,
  input  logic [kcl_pkg::AdcBits-1:0]       analog_two_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              armed_o,
  output logic [kcl_pkg::SymW-1:0]          key_symbol_o,
  output logic                              key_recognized_o,
  output logic [2:0]                        entry_position_o,
  output logic [1:0]                        status_o,
  output logic [2:0]                        tripped_count_o,
  output logic [2:0]                        tripped_index_o,
  output logic [kcl_pkg::DigW-1:0]          led_pattern_o,
  output logic [kcl_pkg::AdcBits-1:0]       shown_one_o,
  output logic [kcl_pkg::AdcBits-1:0]       shown_two_o
);

  localparam int unsigned PosW = $clog2(CodeLength);

  // configuration
  logic [kcl_pkg::CodeW-1:0]   arm_code_q, disarm_code_q;
  logic [kcl_pkg::AdcBits-1:0] trip_one_q, trip_two_q, low_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_code_q    <= kcl_pkg::ArmCodeRst;
      disarm_code_q <= kcl_pkg::DisarmCodeRst;
      trip_one_q    <= kcl_pkg::TripOneRst;
      trip_two_q    <= kcl_pkg::TripTwoRst;
      low_clip_q    <= kcl_pkg::LowClipRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        kcl_pkg::RegArmCode:    arm_code_q    <= cfg_wdata_i[kcl_pkg::CodeW-1:0];
        kcl_pkg::RegDisarmCode: disarm_code_q <= cfg_wdata_i[kcl_pkg::CodeW-1:0];
        kcl_pkg::RegTripOne:    trip_one_q    <= cfg_wdata_i[kcl_pkg::AdcBits-1:0];
        kcl_pkg::RegTripTwo:    trip_two_q    <= cfg_wdata_i[kcl_pkg::AdcBits-1:0];
        kcl_pkg::RegLowClip:    low_clip_q    <= cfg_wdata_i[kcl_pkg::AdcBits-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  logic                        in_valid_q;
  logic                        kind_q;
  logic [kcl_pkg::ScanW-1:0]   scan_q;
  logic [kcl_pkg::DigW-1:0]    dig_q;
  logic [kcl_pkg::AdcBits-1:0] a1_q, a2_q;
  logic                        advance, fire, in_take;

  assign advance    = !out_valid_o || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= kind_i;
      scan_q <= scan_code_i;
      dig_q  <= digital_sensors_i;
      a1_q   <= analog_one_i;
      a2_q   <= analog_two_i;
    end
  end

  // key path and sensor path
  logic                is_key, is_tick;
  kcl_pkg::key_res_t   key_res;
  kcl_pkg::sense_res_t sense_res;
  logic                armed_cur, armed_next;
  logic [PosW-1:0]     pos_next;

  assign is_key  = (kind_q == kcl_pkg::KindKey);
  assign is_tick = (kind_q == kcl_pkg::KindTick);

  kcl_key #(
    .CodeLength(CodeLength)
  ) u_key (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire && is_key),
    .scan_code_i  (scan_q),
    .arm_code_i   (arm_code_q),
    .disarm_code_i(disarm_code_q),
    .key_o        (key_res),
    .armed_o      (armed_cur),
    .armed_next_o (armed_next),
    .pos_next_o   (pos_next)
  );

  kcl_sense u_sense (
    .digital_i   (dig_q),
    .analog_one_i(a1_q),
    .analog_two_i(a2_q),
    .trip_one_i  (trip_one_q),
    .trip_two_i  (trip_two_q),
    .res_o       (sense_res)
  );

  logic [kcl_pkg::DigW-1:0] led_q, led_d;
  logic                     armed_tick, disarmed_tick;

  assign armed_tick    = is_tick && armed_cur;
  assign disarmed_tick = is_tick && !armed_cur;
  assign led_d         = (fire && armed_tick) ? dig_q : led_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= '0;
    end else begin
      led_q <= led_d;
    end
  end

  // output register
  logic                        out_valid_q;
  logic                        armed_oq, recog_oq;
  logic [kcl_pkg::SymW-1:0]    sym_oq;
  logic [2:0]                  pos_oq, cnt_oq, idx_oq;
  kcl_pkg::status_e            status_oq;
  logic [kcl_pkg::DigW-1:0]    led_oq;
  logic [kcl_pkg::AdcBits-1:0] shown1_oq, shown2_oq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      armed_oq  <= armed_next;
      sym_oq    <= is_key ? key_res.symbol : '0;
      recog_oq  <= is_key && key_res.recognized;
      pos_oq    <= 3'(pos_next);
      status_oq <= armed_tick ? sense_res.status : kcl_pkg::StatusReadout;
      cnt_oq    <= armed_tick ? sense_res.count : '0;
      idx_oq    <= armed_tick ? sense_res.index : '0;
      led_oq    <= led_d;
      shown1_oq <= (disarmed_tick && (a1_q >= low_clip_q)) ? a1_q : '0;
      shown2_oq <= (disarmed_tick && (a2_q >= low_clip_q)) ? a2_q : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign armed_o          = armed_oq;
  assign key_symbol_o     = sym_oq;
  assign key_recognized_o = recog_oq;
  assign entry_position_o = pos_oq;
  assign status_o         = status_oq;
  assign tripped_count_o  = cnt_oq;
  assign tripped_index_o  = idx_oq;
  assign led_pattern_o    = led_oq;
  assign shown_one_o      = shown1_oq;
  assign shown_two_o      = shown2_oq;

  // an alarm status only comes from an armed panel
  a_status_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != kcl_pkg::StatusReadout) |-> armed_o)
    else $error("alarm status while disarmed");

  // a single trip reports a count of one
  a_one_trip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == kcl_pkg::StatusOneTrip) |-> tripped_count_o == 3'd1)
    else $error("single trip status with wrong count");

  // input side stalls only when both registers hold a word and the output is blocked
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without back-pressure");

  // a stalled result holds, and the input word behind it does not move the lock state
  a_hold_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> armed_cur == $past(armed_cur))
    else $error("lock state changed during output stall");

endmodule

[sv/kcl_key.sv]
module kcl_key #(
  parameter int unsigned CodeLength = 6,
  localparam int unsigned PosW = $clog2(CodeLength)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [kcl_pkg::ScanW-1:0]     scan_code_i,
  input  logic [kcl_pkg::CodeW-1:0]     arm_code_i,
  input  logic [kcl_pkg::CodeW-1:0]     disarm_code_i,
  output kcl_pkg::key_res_t             key_o,
  output logic                          armed_o,
  output logic                          armed_next_o,
  output logic [PosW-1:0]               pos_next_o
);

  localparam logic [PosW:0]   LenExt  = (PosW + 1)'(CodeLength);
  localparam logic [PosW-1:0] LastPos = PosW'(CodeLength - 1);

  logic [PosW-1:0]       entry_pos_q, entry_pos_d;
  logic [CodeLength-1:0] arm_match_q, arm_match_d;
  logic [CodeLength-1:0] disarm_match_q, disarm_match_d;
  logic                  armed_q, armed_d;

  logic [kcl_pkg::SymW-1:0] sym;
  logic                     known;
  logic [PosW-1:0]          pos;
  logic [3:0]               pos4;
  logic [63:0]              arm_ext, disarm_ext;
  logic [kcl_pkg::SymW-1:0] arm_sym, disarm_sym;
  logic                     arm_hit, disarm_hit;

  always_comb begin
    sym   = '0;
    known = 1'b0;
    for (int i = 0; i < kcl_pkg::NumKeys; i++) begin
      if (kcl_pkg::ScanTable[i] == scan_code_i) begin
        sym   = kcl_pkg::SymW'(i);
        known = 1'b1;
      end
    end
  end

  // symbols past the code register read as zero
  assign pos        = ({1'b0, entry_pos_q} >= LenExt) ? '0 : entry_pos_q;
  assign pos4       = 4'(pos);
  assign arm_ext    = 64'(arm_code_i);
  assign disarm_ext = 64'(disarm_code_i);
  assign arm_sym    = arm_ext[{pos4, 2'b00} +: kcl_pkg::SymW];
  assign disarm_sym = disarm_ext[{pos4, 2'b00} +: kcl_pkg::SymW];
  assign arm_hit    = known && (sym < kcl_pkg::SymEquals) && (sym == arm_sym);
  assign disarm_hit = known && (sym < kcl_pkg::SymEquals) && (sym == disarm_sym);

  always_comb begin
    arm_match_d    = arm_match_q;
    disarm_match_d = disarm_match_q;
    entry_pos_d    = entry_pos_q;
    armed_d        = armed_q;
    if (fire_i) begin
      for (int b = 0; b < CodeLength; b++) begin
        if (PosW'(b) == pos) begin
          arm_match_d[b]    = arm_hit;
          disarm_match_d[b] = disarm_hit;
        end
      end
      if (pos == LastPos) begin
        // disarm wins when both codes complete
        if (&disarm_match_d) begin
          armed_d = 1'b0;
        end else if (&arm_match_d) begin
          armed_d = 1'b1;
        end
        entry_pos_d = '0;
      end else begin
        entry_pos_d = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_pos_q    <= '0;
      arm_match_q    <= '0;
      disarm_match_q <= '0;
      armed_q        <= 1'b0;
    end else begin
      entry_pos_q    <= entry_pos_d;
      arm_match_q    <= arm_match_d;
      disarm_match_q <= disarm_match_d;
      armed_q        <= armed_d;
    end
  end

  assign key_o.symbol     = sym;
  assign key_o.recognized = known;
  assign armed_o          = armed_q;
  assign armed_next_o     = armed_d;
  assign pos_next_o       = entry_pos_d;

endmodule

[sv/kcl_sense.sv]
module kcl_sense (
  input  logic [kcl_pkg::DigW-1:0]    digital_i,
  input  logic [kcl_pkg::AdcBits-1:0] analog_one_i,
  input  logic [kcl_pkg::AdcBits-1:0] analog_two_i,
  input  logic [kcl_pkg::AdcBits-1:0] trip_one_i,
  input  logic [kcl_pkg::AdcBits-1:0] trip_two_i,
  output kcl_pkg::sense_res_t         res_o
);

  logic [kcl_pkg::NumTrip-1:0] trips;
  logic [2:0]                  cnt;
  logic [2:0]                  first;

  assign trips = {analog_two_i >= trip_two_i, analog_one_i >= trip_one_i, digital_i};

  always_comb begin
    cnt   = '0;
    first = '0;
    for (int i = 0; i < kcl_pkg::NumTrip; i++) begin
      cnt = cnt + 3'(trips[i]);
    end
    // walk down so the lowest tripped sensor is left standing
    for (int i = kcl_pkg::NumTrip - 1; i >= 0; i--) begin
      if (trips[i]) begin
        first = 3'(i);
      end
    end
  end

  always_comb begin
    res_o.count = cnt;
    res_o.index = first;
    priority if (cnt == 3'd0) begin
      res_o.status = kcl_pkg::StatusAllClear;
    end else if (cnt == 3'd1) begin
      res_o.status = kcl_pkg::StatusOneTrip;
    end else begin
      res_o.status = kcl_pkg::StatusIntrusion;
    end
  end

endmodule
